// File: design/lfu_pkg.sv
package lfu_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int USE_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch request, clear scan state
    logic scan;      // examine entry at scan index
    logic commit;    // apply the update
    logic respond;   // drive result strobe
  } lfu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } lfu_sts_t;

endpackage

// File: design/lfu_cache_table.sv
// Channel   Direction  Signals
// config    in         cfg_we, cfg_data (capacity_in_use)
// request   in         start, opcode, lookup_key, store_value; busy back
// result    out        done, hit, read_value, evicted, evicted_key
//
// A request scans every entry in sequence, one entry per cycle, then commits and
// responds; done is registered from the respond state.
// busy is high from the cycle after acceptance until done; one request at a time.
// rst is synchronous: clears valid bits, occupancy, capacity to 16.
// done is a one-cycle strobe; the receiver cannot stall.
module lfu_cache_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_data,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode,
  input  logic signed [lfu_pkg::KEY_W-1:0]  lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  store_value,
  output logic                              done,
  output logic                              hit,
  output logic signed [lfu_pkg::VAL_W-1:0]  read_value,
  output logic                              evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key
);

  lfu_pkg::lfu_cmd_t cmd;
  lfu_pkg::lfu_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
  );

  lfu_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .opcode(opcode), .lookup_key(lookup_key), .store_value(store_value),
    .done(done), .hit(hit), .read_value(read_value),
    .evicted(evicted), .evicted_key(evicted_key)
  );

endmodule

// File: design/lfu_ctrl.sv
module lfu_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lfu_pkg::lfu_sts_t sts,
  output logic              busy,
  output lfu_pkg::lfu_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_SCAN;
      S_SCAN:   if (sts.scan_last) state_next = S_COMMIT;
      S_COMMIT: state_next = S_RESP;
      S_RESP:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.scan = (state == S_SCAN);
  assign cmd.commit = (state == S_COMMIT);
  assign cmd.respond = (state == S_RESP);

  a_load_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.scan) else $error("load did not enter scan");
  a_commit_then_resp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> cmd.respond) else $error("commit not followed by respond");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.scan, cmd.commit, cmd.respond})) else $error("overlapping commands");

endmodule

// File: design/lfu_dp.sv
module lfu_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  lfu_pkg::lfu_cmd_t                 cmd,
  output lfu_pkg::lfu_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_data,
  input  logic                              opcode,
  input  logic signed [lfu_pkg::KEY_W-1:0]  lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  store_value,
  output logic                              done,
  output logic                              hit,
  output logic signed [lfu_pkg::VAL_W-1:0]  read_value,
  output logic                              evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]  evicted_key
);

  localparam int N = lfu_pkg::CAPACITY;
  localparam int IW = lfu_pkg::IDX_W;
  localparam int CW = lfu_pkg::CNT_W;

  // entry store: read by the scan mux at the scan index; commit also reads found, victim and all ranks
  logic [N-1:0]                 vld;
  logic [lfu_pkg::KEY_W-1:0]    key_q [N];
  logic [lfu_pkg::VAL_W-1:0]    val_q [N];
  logic [lfu_pkg::USE_W-1:0]    use_q [N];
  logic [IW-1:0]                rank_q [N];
  logic [CW-1:0]                occ;
  logic [lfu_pkg::CAP_W-1:0]    cap_reg;

  // latched request
  logic                         op_r;
  logic [lfu_pkg::KEY_W-1:0]    key_r;
  logic [lfu_pkg::VAL_W-1:0]    val_r;

  // scan state
  logic [IW-1:0]                idx;
  logic                         fnd;
  logic [IW-1:0]                fnd_idx;
  logic                         vic_got;
  logic [IW-1:0]                vic_idx;
  logic [lfu_pkg::USE_W-1:0]    vic_use;
  logic [IW-1:0]                vic_rank;
  logic                         fre_got;
  logic [IW-1:0]                fre_idx;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) cap_reg <= lfu_pkg::CAP_RESET;
    else if (cfg_we) cap_reg <= cfg_data;
  end

  logic [CW-1:0] cap_eff;
  always_comb begin
    if (32'(cap_reg) > N) cap_eff = CW'(N);
    else cap_eff = CW'(cap_reg);
  end

  assign sts.scan_last = (idx == IW'(N - 1));

  // scan: one entry per cycle, key match, victim and free slot
  logic better;
  always_comb begin
    better = !vic_got || (use_q[idx] < vic_use) ||
             ((use_q[idx] == vic_use) && (rank_q[idx] > vic_rank));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      fnd <= 1'b0;
      vic_got <= 1'b0;
      fre_got <= 1'b0;
    end else if (cmd.load) begin
      idx <= '0;
      fnd <= 1'b0;
      vic_got <= 1'b0;
      fre_got <= 1'b0;
    end else if (cmd.scan) begin
      idx <= idx + 1'b1;
      if (vld[idx]) begin
        if (!fnd && key_q[idx] == key_r) begin
          fnd <= 1'b1;
          fnd_idx <= idx;
        end
        if (better) begin
          vic_got <= 1'b1;
          vic_idx <= idx;
          vic_use <= use_q[idx];
          vic_rank <= rank_q[idx];
        end
      end else if (!fre_got) begin
        fre_got <= 1'b1;
        fre_idx <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode;
      key_r <= lookup_key;
      val_r <= store_value;
    end
  end

  // commit decisions
  logic ins, do_ev;
  logic [IW-1:0] slot;
  always_comb begin
    do_ev = 1'b0;
    ins = 1'b0;
    slot = fre_idx;
    if (!fnd && op_r == lfu_pkg::OP_PUT && cap_eff != '0) begin
      if (occ >= cap_eff && vic_got) begin
        do_ev = 1'b1;
        ins = 1'b1;
        slot = vic_idx;
      end else if (fre_got) begin
        ins = 1'b1;
      end
    end
  end

  // entry update
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      occ <= '0;
    end else if (cmd.commit) begin
      if (fnd) begin
        for (int i = 0; i < N; i++)
          if (vld[i] && rank_q[i] < rank_q[fnd_idx]) rank_q[i] <= rank_q[i] + 1'b1;
        rank_q[fnd_idx] <= '0;
        if (use_q[fnd_idx] != '1) use_q[fnd_idx] <= use_q[fnd_idx] + 1'b1;
        if (op_r == lfu_pkg::OP_PUT) val_q[fnd_idx] <= val_r;
      end else if (ins) begin
        // evict-then-insert: entries older than victim keep rank+1-1 net
        for (int i = 0; i < N; i++)
          if (vld[i] && IW'(i) != slot) begin
            if (!do_ev || rank_q[i] < vic_rank) rank_q[i] <= rank_q[i] + 1'b1;
          end
        vld[slot] <= 1'b1;
        key_q[slot] <= key_r;
        val_q[slot] <= val_r;
        use_q[slot] <= '0;
        rank_q[slot] <= '0;
        if (!do_ev) occ <= occ + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.respond;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit <= fnd;
      read_value <= (fnd && op_r == lfu_pkg::OP_GET) ? val_q[fnd_idx] : '1;
      evicted <= do_ev;
      evicted_key <= do_ev ? key_q[vic_idx] : '0;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(N)) else $error("occupancy over capacity");
  a_occ_matches: assert property (@(posedge clk) disable iff (rst)
    32'(occ) == $countones(vld)) else $error("occupancy and valid bits disagree");
  a_ev_is_miss: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_ev |-> !fnd) else $error("eviction on hit");

endmodule

// File: bench/lfu_cache_checker.sv
module lfu_cache_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]         cfg_data,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              opcode,
  input  logic signed [lfu_pkg::KEY_W-1:0]  lookup_key,
  input  logic signed [lfu_pkg::VAL_W-1:0]  store_value,
  input  logic                              done,
  input  logic                              hit,
  input  logic signed [lfu_pkg::VAL_W-1:0]  read_value,
  input  logic                              evicted,
  input  logic signed [lfu_pkg::KEY_W-1:0]  evicted_key,
  output int                                pending,
  output int                                failures,
  output int                                hit_total,
  output int                                evict_total
);
  import lfu_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } lookup_result_t;

  // shadow copy of the table
  logic [CAP_W-1:0] cap_reg;
  logic             slot_valid [CAPACITY];
  logic [KEY_W-1:0] slot_key   [CAPACITY];
  logic [VAL_W-1:0] slot_value [CAPACITY];
  logic [USE_W-1:0] slot_uses  [CAPACITY];
  int               slot_age   [CAPACITY];
  int               occupancy;

  lookup_result_t expected_results[$];

  assign pending = expected_results.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    failures++;
  endtask

  // move slot s to the front of the recency order
  task automatic touch_slot(input int s);
    int r;
    r = slot_age[s];
    for (int i = 0; i < CAPACITY; i++)
      if (slot_valid[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endtask

  task automatic apply_request(input logic op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val, output lookup_result_t res);
    int cap_eff, found, slot, r;
    bit got;
    cap_eff = (cap_reg > CAPACITY) ? CAPACITY : int'(cap_reg);
    res = '{hit: 1'b0, read_value: '1, evicted: 1'b0, evicted_key: '0};
    found = -1;
    for (int i = 0; i < CAPACITY; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    if (found >= 0) begin
      res.hit = 1'b1;
      if (op == OP_GET) res.read_value = slot_value[found];
      else slot_value[found] = val;
      if (slot_uses[found] != '1) slot_uses[found]++;
      touch_slot(found);
    end else if (op == OP_PUT && cap_eff != 0) begin
      slot = 0;
      got = 0;
      // victim: fewest uses, oldest among equals
      if (occupancy >= cap_eff) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (slot_valid[i] && (!got || slot_uses[i] < slot_uses[slot] ||
              (slot_uses[i] == slot_uses[slot] && slot_age[i] > slot_age[slot]))) begin
            slot = i;
            got = 1;
          end
        end
        if (got) begin
          r = slot_age[slot];
          res.evicted = 1'b1;
          res.evicted_key = slot_key[slot];
          slot_valid[slot] = 1'b0;
          occupancy--;
          for (int i = 0; i < CAPACITY; i++)
            if (slot_valid[i] && slot_age[i] > r) slot_age[i]--;
        end
      end
      if (!got) begin
        for (int i = CAPACITY - 1; i >= 0; i--)
          if (!slot_valid[i]) begin
            slot = i;
            got = 1;
          end
      end
      if (got) begin
        for (int i = 0; i < CAPACITY; i++)
          if (slot_valid[i]) slot_age[i]++;
        slot_valid[slot] = 1'b1;
        slot_key[slot] = key;
        slot_value[slot] = val;
        slot_uses[slot] = '0;
        slot_age[slot] = 0;
        occupancy++;
      end
    end
  endtask

  initial begin
    failures = 0;
    hit_total = 0;
    evict_total = 0;
  end

  always @(posedge clk) begin
    lookup_result_t res, want;
    if (rst) begin
      cap_reg = CAP_RESET;
      occupancy = 0;
      for (int i = 0; i < CAPACITY; i++) slot_valid[i] = 1'b0;
      expected_results.delete();
    end else begin
      if (cfg_we) cap_reg = cfg_data;
      // result side first: one request in flight at a time
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result at %0t", $realtime);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit) report("hit", hit, want.hit);
          if (read_value !== want.read_value)
            report("read_value", read_value, want.read_value);
          if (evicted !== want.evicted) report("evicted", evicted, want.evicted);
          if (evicted_key !== want.evicted_key)
            report("evicted_key", evicted_key, want.evicted_key);
          if (want.hit) hit_total++;
          if (want.evicted) evict_total++;
        end
      end
      if (start && !busy) begin
        apply_request(opcode, lookup_key, store_value, res);
        expected_results.push_back(res);
      end
    end
  end

endmodule

// File: bench/lfu_cache_table_tb.sv
module lfu_cache_table_tb;
  import lfu_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_we = 1'b0;
  logic [CAP_W-1:0]         cfg_data = '0;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     opcode = OP_GET;
  logic signed [KEY_W-1:0]  lookup_key = '0;
  logic signed [VAL_W-1:0]  store_value = '0;
  logic                     done;
  logic                     hit;
  logic signed [VAL_W-1:0]  read_value;
  logic                     evicted;
  logic signed [KEY_W-1:0]  evicted_key;

  int pending, failures, hit_total, evict_total;
  int cycles = 0;
  int sent = 0;
  int gap_pct = 7;
  int pool_n = 20;
  logic [KEY_W-1:0] key_pool [20];
  logic [CAP_W-1:0] phase_caps [7] = '{5'd2, 5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd8};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lfu_cache_table u_dut (.*);

  lfu_cache_checker u_chk (.*);

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** lfu_cache_table: FAILED **");
      $finish;
    end
  end

  // present one request and hold it until accepted
  task automatic send(input logic op, input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    lookup_key <= key;
    store_value <= val;
    do @(posedge clk); while (busy);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return key_pool[$urandom_range(0, pool_n - 1)];
    if (r < 85) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return '1;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int cap_eff;
    for (int i = 0; i < 20; i++) key_pool[i] = $urandom;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extreme keys and values, hits, misses, updates
    send(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send(OP_PUT, '1, '0);
    send(OP_PUT, '0, '1);
    send(OP_GET, 32'h8000_0000, '0);
    send(OP_GET, 32'h7FFF_FFFF, '1);
    send(OP_GET, '1, '0);
    send(OP_GET, '0, '0);
    send(OP_GET, 32'd5, '0);
    send(OP_PUT, '1, 32'h1234_5678);
    send(OP_GET, '1, '0);
    // lower capacity below occupancy: puts evict without growing
    write_capacity(5'd2);
    send(OP_PUT, 32'd11, 32'd1);
    send(OP_PUT, 32'd12, 32'd2);
    send(OP_GET, 32'd11, '0);
    // capacity zero stores nothing, old entries still readable
    write_capacity(5'd0);
    send(OP_PUT, 32'd13, 32'd3);
    send(OP_GET, 32'd13, '0);
    send(OP_GET, 32'd11, '0);
    send(OP_PUT, 32'd11, 32'd4);

    // random phases over several capacities
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      cap_eff = (phase_caps[p] > CAPACITY) ? CAPACITY : int'(phase_caps[p]);
      pool_n = (cap_eff + 4 > 20) ? 20 : cap_eff + 4;
      gap_pct = (p == 5) ? 0 : 7;
      repeat (85) send($urandom_range(0, 99) < 55 ? OP_PUT : OP_GET, pick_key(), $urandom);
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3 * (CAPACITY + 3)) @(negedge clk);
    $display("%0d requests over capacities 0 to 31, extreme keys included", sent);
    $display("%0d hits and %0d evictions checked", hit_total, evict_total);
    if (failures == 0 && pending == 0)
      $display("** lfu_cache_table: PASSED **");
    else
      $display("** lfu_cache_table: FAILED **");
    $finish;
  end

endmodule
